@@ hw/rtl/gsp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the grid segment placer: grid geometry,
// heading codes and the structs the sequencer passes to row memory and output.
// ----------------------------------------------------------------------------
package gsp_pkg;

   localparam int GRID_SIZE = 16;
   localparam int IDX_W     = $clog2(GRID_SIZE);
   localparam int LEN_W     = $clog2(GRID_SIZE + 1);
   localparam int SPAN_W    = LEN_W + 1;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [GRID_SIZE-1:0] row_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [1:0]           heading_type;

   localparam heading_type HEAD_NORTH = 2'd0;
   localparam heading_type HEAD_SOUTH = 2'd1;
   localparam heading_type HEAD_EAST  = 2'd2;
   localparam heading_type HEAD_WEST  = 2'd3;

   // One access request to the row memory. The write sets the cells selected by
   // wr_mask; other cells keep their contents, or read as free on a first write.
   typedef struct packed {
      logic    rd_en;
      idx_type rd_addr;
      logic    wr_en;
      idx_type wr_addr;
      row_type wr_mask;
   } mem_req_type;

   // Finished verdict offered by the sequencer to the output register.
   typedef struct packed {
      logic valid;
      logic placed;
   } verdict_type;

endpackage

@@ hw/rtl/grid_segment_placer_core.sv @@
// ----------------------------------------------------------------------------
// grid_segment_placer_core
// Places straight segments on a 16 x 16 occupancy grid held in row memory.
// ----------------------------------------------------------------------------
// Usage: a request word on the req_ channel names a start row and column, a
// heading (north, south, east, west) and a run length. The block answers each
// request with exactly one rsp_ word whose rsp_placed bit is 1 when every
// cell of the run was inside the grid and free; those cells are then marked.
// On failure the grid is left untouched. A zero length always succeeds.
// The grid lives in a 16-word memory, one word per row, with a registered
// read. One request is worked on at a time; req_stall stays high while it is
// in progress. A run of n cells along a column reads n rows and then writes n
// rows before its result is offered. A run along a row reads and writes one
// word; a zero length or a run past an edge is answered without touching the
// memory. The result sits in an output register, so a stalled rsp word does
// not hold up the next request until that next result is ready.
// Reset marks every row as free at once through per-row valid bits; no
// clearing pass is needed and requests are accepted right after reset.
// ----------------------------------------------------------------------------
module grid_segment_placer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gsp_pkg::idx_type     req_start_row,
   input  gsp_pkg::idx_type     req_start_col,
   input  gsp_pkg::heading_type req_heading,
   input  gsp_pkg::len_type     req_run_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_placed
);
   import gsp_pkg::*;

   logic        busy;
   logic        req_take;
   logic        out_free;
   mem_req_type mem_req;
   row_type     rd_data;
   verdict_type verdict;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_placed_ff, rsp_placed_in;

   // The sequencer takes a word only when it has nothing in progress.
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;

   // The output register can load when it is empty or is being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   gsp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .start_row  (req_start_row),
      .start_col  (req_start_col),
      .heading    (req_heading),
      .run_length (req_run_length),
      .out_free   (out_free),
      .busy       (busy),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .verdict    (verdict)
   );

   gsp_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_placed_in = rsp_placed_ff;
      if (out_free) begin
         rsp_valid_in  = verdict.valid;
         rsp_placed_in = verdict.placed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_placed_ff <= rsp_placed_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_placed = rsp_placed_ff;

endmodule

@@ hw/rtl/gsp_row_mem.sv @@
// ----------------------------------------------------------------------------
// gsp_row_mem
// Occupancy rows: one synchronous memory word per grid row, registered read,
// bit-masked write, and a valid bit per row so that reset reads as all free.
// ----------------------------------------------------------------------------
module gsp_row_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  gsp_pkg::mem_req_type mem_req,
   output gsp_pkg::row_type     rd_data
);
   import gsp_pkg::*;

   row_type              mem_ff [GRID_SIZE];
   logic [GRID_SIZE-1:0] row_valid_ff;
   row_type              rd_data_ff;

   // A row never written since reset holds garbage, so its first write stores
   // the whole word; later writes only set the masked cells.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         for (int b = 0; b < GRID_SIZE; b++) begin
            if (!row_valid_ff[mem_req.wr_addr] || mem_req.wr_mask[b]) begin
               mem_ff[mem_req.wr_addr][b] <= mem_req.wr_mask[b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         row_valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= row_valid_ff[mem_req.rd_addr] ? mem_ff[mem_req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gsp_seq.sv @@
// ----------------------------------------------------------------------------
// gsp_seq
// Request sequencer: checks the run against the grid edges, reads the touched
// rows to look for occupied cells, then writes the run into the rows.
// ----------------------------------------------------------------------------
module gsp_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_take,
   input  gsp_pkg::idx_type     start_row,
   input  gsp_pkg::idx_type     start_col,
   input  gsp_pkg::heading_type heading,
   input  gsp_pkg::len_type     run_length,
   input  logic                 out_free,
   output logic                 busy,
   output gsp_pkg::mem_req_type mem_req,
   input  gsp_pkg::row_type     rd_data,
   output gsp_pkg::verdict_type verdict
);
   import gsp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MARK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   idx_type   row_ff, row_in;
   idx_type   first_row_ff, first_row_in;
   len_type   left_ff, left_in;
   len_type   count_ff, count_in;
   logic      step_up_ff, step_up_in;
   row_type   mask_ff, mask_in;
   logic      pend_ff, pend_in;
   logic      result_ff, result_in;

   // Geometry of a new request.
   logic [SPAN_W-1:0] row_x, col_x, len_x, lo_x, hi_x;
   logic              fits_grid;
   logic              vertical;
   row_type           run_mask;
   idx_type           next_row;

   always_comb begin
      row_x    = SPAN_W'(start_row);
      col_x    = SPAN_W'(start_col);
      len_x    = SPAN_W'(run_length);
      vertical = (heading == HEAD_NORTH) || (heading == HEAD_SOUTH);
      lo_x     = col_x;
      hi_x     = col_x;
      case (heading)
         HEAD_NORTH: fits_grid = len_x <= row_x + SPAN_W'(1);
         HEAD_SOUTH: fits_grid = row_x + len_x <= SPAN_W'(GRID_SIZE);
         HEAD_EAST: begin
            fits_grid = col_x + len_x <= SPAN_W'(GRID_SIZE);
            hi_x      = col_x + len_x - SPAN_W'(1);
         end
         HEAD_WEST: begin
            fits_grid = len_x <= col_x + SPAN_W'(1);
            lo_x      = col_x + SPAN_W'(1) - len_x;
         end
         default: fits_grid = 1'b0;
      endcase
      if (vertical) begin
         run_mask = row_type'(1) << start_col;
      end else begin
         for (int c = 0; c < GRID_SIZE; c++) begin
            run_mask[c] = (SPAN_W'(c) >= lo_x) && (SPAN_W'(c) <= hi_x);
         end
      end
   end

   assign next_row = step_up_ff ? row_ff - idx_type'(1) : row_ff + idx_type'(1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      first_row_in = first_row_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      step_up_in   = step_up_ff;
      mask_in      = mask_ff;
      pend_in      = 1'b0;
      result_in    = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               first_row_in = start_row;
               row_in       = start_row;
               step_up_in   = heading == HEAD_NORTH;
               mask_in      = run_mask;
               count_in     = vertical ? run_length : len_type'(1);
               left_in      = vertical ? run_length : len_type'(1);
               if (run_length == '0) begin
                  result_in = 1'b1;
                  state_in  = ST_DONE;
               end else if (!fits_grid) begin
                  result_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (pend_ff && ((rd_data & mask_ff) != '0)) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else if (left_ff == '0 && !pend_ff) begin
               row_in   = first_row_ff;
               left_in  = count_ff;
               state_in = ST_MARK;
            end else if (left_ff != '0) begin
               row_in  = next_row;
               left_in = left_ff - len_type'(1);
               pend_in = 1'b1;
            end
         end
         ST_MARK: begin
            if (left_ff == '0) begin
               result_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               row_in  = next_row;
               left_in = left_ff - len_type'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         left_ff  <= left_in;
      end
      row_ff       <= row_in;
      first_row_ff <= first_row_in;
      count_ff     <= count_in;
      step_up_ff   <= step_up_in;
      mask_ff      <= mask_in;
      result_ff    <= result_in;
   end

   always_comb begin
      mem_req.rd_en   = (state_ff == ST_CHECK) && (left_ff != '0);
      mem_req.rd_addr = row_ff;
      mem_req.wr_en   = (state_ff == ST_MARK) && (left_ff != '0);
      mem_req.wr_addr = row_ff;
      mem_req.wr_mask = mask_ff;
   end

   assign busy           = state_ff != ST_IDLE;
   assign verdict.valid  = state_ff == ST_DONE;
   assign verdict.placed = result_ff;

   a_write_only_marking: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_MARK) && !mem_req.rd_en)
      else $error("row write outside the marking phase");

   a_pending_read_in_check: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_CHECK)
      else $error("read data pending outside the check phase");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CHECK) || (state_ff == ST_MARK)) |->
         left_ff <= len_type'(GRID_SIZE))
      else $error("remaining row count exceeds the grid size");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && !out_free |=> state_ff == ST_DONE)
      else $error("verdict dropped while the output register was full");

endmodule
